[rtl/dna_canonical_minimizer_core_defines.svh]
// ----------------------------------------------------------------------------
// dna_canonical_minimizer_core_defines
// Assertion macros shared by the minimizer core.
// ----------------------------------------------------------------------------
`ifndef DNA_CANONICAL_MINIMIZER_CORE_DEFINES_SVH
`define DNA_CANONICAL_MINIMIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define DCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dcm_pkg.sv]
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types, constants and the hash mix step of the minimizer core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcm_pkg;

    localparam int SMER_LEN_DEF   = 19;
    localparam int WINDOW_LEN_DEF = 16;
    localparam int BASE_W         = 8;
    localparam int OUT_W          = 38;
    localparam int KEY_W          = 64;
    localparam int MIX_STEPS      = 7;
    localparam int STEP_W         = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              load;
        logic              clear;
        logic              hash;
        logic [STEP_W-1:0] step;
        logic              write;
        logic              scan_start;
        logic              rd;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic will_hash;
        logic in_last;
        logic last;
        logic full;
        logic scan_end;
        logic need_emit;
        logic out_free;
    } t_status;

    function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] k,
                                                  input logic [STEP_W-1:0] step);
        logic [KEY_W-1:0] r;
        case (step)
            3'd0:    r = ~k + (k << 21);
            3'd1:    r = k ^ (k >> 24);
            3'd2:    r = k + (k << 3) + (k << 8);
            3'd3:    r = k ^ (k >> 14);
            3'd4:    r = k + (k << 2) + (k << 4);
            3'd5:    r = k ^ (k >> 28);
            3'd6:    r = k + (k << 31);
            default: r = k;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/dcm_ctrl.sv]
// ----------------------------------------------------------------------------
// dcm_ctrl
// Sequencer: accept, hash steps, window write, window scan, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcm_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  dcm_pkg::t_status   i_status,
    output dcm_pkg::t_cmd            o_cmd
);
    import dcm_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_cmd.step = r_step;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.will_hash) begin
                        n_state = ST_HASH;
                        n_step  = '0;
                    end else if (i_status.in_last) begin
                        o_cmd.clear = 1'b1;
                    end
                end
            end
            ST_HASH: begin
                o_cmd.hash = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(MIX_STEPS - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_status.full) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    o_cmd.clear = i_status.last;
                    n_state     = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_status.scan_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_status.need_emit) begin
                    o_cmd.clear = i_status.last;
                    n_state     = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = i_status.last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/dcm_datapath.sv]
// ----------------------------------------------------------------------------
// dcm_datapath
// Rolling s-mers, hash register, hash window memory, minimum and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcm_datapath #(
    parameter int SMER_LEN   = dcm_pkg::SMER_LEN_DEF,
    parameter int WINDOW_LEN = dcm_pkg::WINDOW_LEN_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [dcm_pkg::BASE_W-1:0]  i_base_char,
    input  wire                         i_last_base,
    input  wire                         i_out_stall,
    output logic                        o_out_valid,
    output logic [dcm_pkg::OUT_W-1:0]   o_minimizer_hash,
    input  wire  dcm_pkg::t_cmd         i_cmd,
    output dcm_pkg::t_status            o_status
);
    import dcm_pkg::*;

    localparam int MER_W      = 2 * SMER_LEN;
    localparam int FULL_COUNT = SMER_LEN + WINDOW_LEN - 1;
    localparam int CNT_W      = $clog2(FULL_COUNT + 1);
    localparam int WIN_AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [MER_W-1:0]     r_fwd, n_fwd;
    logic [MER_W-1:0]     r_rev, n_rev;
    logic [MER_W-1:0]     canon;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [1:0]           code;
    logic                 r_last;
    logic [KEY_W-1:0]     r_key;
    logic [MER_W-1:0]     r_win [WINDOW_LEN];
    logic [WIN_AW-1:0]    r_win_pos;
    logic [WIN_AW-1:0]    r_scan_idx;
    logic [MER_W-1:0]     r_rd_data;
    logic                 r_rd_vld;
    logic                 r_first;
    logic [MER_W-1:0]     r_min;
    logic [MER_W-1:0]     r_last_emit;
    logic                 r_emitted_any;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_hash;
    logic                 out_free;

    assign code  = i_base_char[2:1];
    assign n_fwd = MER_W'({r_fwd, code});
    assign n_rev = (r_rev >> 2) | (MER_W'(code ^ 2'b10) << (MER_W - 2));
    assign n_cnt = (r_cnt < CNT_W'(FULL_COUNT)) ? r_cnt + CNT_W'(1) : r_cnt;
    assign canon = (n_fwd < n_rev) ? n_fwd : n_rev;

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.will_hash = (n_cnt >= CNT_W'(SMER_LEN));
    assign o_status.in_last   = i_last_base;
    assign o_status.last      = r_last;
    assign o_status.full      = (r_cnt >= CNT_W'(FULL_COUNT));
    assign o_status.scan_end  = (r_scan_idx == WIN_AW'(WINDOW_LEN - 1));
    assign o_status.need_emit = !r_emitted_any || (r_min != r_last_emit);
    assign o_status.out_free  = out_free;

    assign o_out_valid      = r_out_valid;
    assign o_minimizer_hash = r_out_hash;

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fwd         <= '0;
            r_rev         <= '0;
            r_cnt         <= '0;
            r_win_pos     <= '0;
            r_last_emit   <= '0;
            r_emitted_any <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
                r_cnt <= n_cnt;
            end
            if (i_cmd.write) begin
                r_win_pos <= (r_win_pos == WIN_AW'(WINDOW_LEN - 1)) ? '0
                                                                    : r_win_pos + 1'b1;
            end
            if (i_cmd.emit) begin
                r_last_emit   <= r_min;
                r_emitted_any <= 1'b1;
            end
        end
    end

    // hash register and last flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= KEY_W'(canon);
            r_last <= i_last_base;
        end else if (i_cmd.hash) begin
            r_key  <= mix_step(r_key, i_cmd.step);
        end
    end

    // window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_win[r_win_pos] <= r_key[MER_W-1:0];
        end
        r_rd_data <= r_win[r_scan_idx];
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_scan_idx <= '0;
            r_first    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_first    <= 1'b1;
            end else begin
                if (i_cmd.rd) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    r_first <= 1'b0;
                end
            end
        end
    end

    // fold window minimum
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_first || (r_rd_data < r_min)) begin
                r_min <= r_rd_data;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_hash <= OUT_W'(r_min);
        end
    end

endmodule

`default_nettype wire

[rtl/dna_canonical_minimizer_core.sv]
// ----------------------------------------------------------------------------
// dna_canonical_minimizer_core
// Canonical s-mer minimizer over a stream of DNA bases.
//
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  i_base_char, i_last_base
// result    out        o_out_valid / i_out_stall o_minimizer_hash
//
// A base before the s-mer fills takes only the accept step; a hashed base
// before the window is full runs accept, 7 hash mix steps and window write.
// Once the window is full an item also runs a scan of the window memory
// at one entry per cycle, a drain step and an emit step. A held result
// stalls only the emit step.
// Reset is synchronous; the window memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dna_canonical_minimizer_core_defines.svh"

module dna_canonical_minimizer_core #(
    parameter int SMER_LEN   = dcm_pkg::SMER_LEN_DEF,
    parameter int WINDOW_LEN = dcm_pkg::WINDOW_LEN_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire  [dcm_pkg::BASE_W-1:0] i_base_char,
    input  wire                        i_last_base,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [dcm_pkg::OUT_W-1:0]  o_minimizer_hash
);
    import dcm_pkg::*;

    t_cmd    cmd;
    t_status status;

    dcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dcm_datapath #(
        .SMER_LEN   (SMER_LEN),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_base_char      (i_base_char),
        .i_last_base      (i_last_base),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_minimizer_hash (o_minimizer_hash),
        .i_cmd            (cmd),
        .o_status         (status)
    );

    `DCM_ASSERT_NOW(a_load_on_request, cmd.load, i_in_valid && !o_in_stall, "load without request")
    `DCM_ASSERT_NOW(a_emit_when_free, cmd.emit, status.out_free, "emit into held result")
    `DCM_ASSERT_NEXT(a_emit_shows, cmd.emit, o_out_valid, "emitted result not shown")
    `DCM_ASSERT_NOW(a_no_load_emit, cmd.emit, !cmd.load && !cmd.hash, "emit overlaps item work")

endmodule

`default_nettype wire
